>>> rtl/imhq_pkg.sv
package imhq_pkg;

  localparam int CAPACITY = 1024;
  localparam int HW = $clog2(CAPACITY);
  localparam int CW = HW + 1;
  localparam int KW = 32;

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_POP = 3'd1;
  localparam logic [2:0] OP_REMOVE = 3'd2;
  localparam logic [2:0] OP_UPDATE = 3'd3;
  localparam logic [2:0] OP_UPDATE_PAY = 3'd4;
  localparam logic [2:0] OP_PEEK = 3'd5;
  localparam logic [2:0] OP_CLEAR = 3'd6;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_DEAD = 2'd3;

  typedef struct packed {
    logic [2:0]           opcode;
    logic signed [KW-1:0] new_key;
    logic [31:0]          payload;
    logic [HW-1:0]        handle;
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [HW-1:0]        out_handle;
    logic signed [KW-1:0] out_key;
    logic [31:0]          out_payload;
    logic [CW-1:0]        entry_count;
  } rsp_t;

endpackage

>>> rtl/imhq_ram.sv
module imhq_ram #(
  parameter int W = 32,
  parameter int D = 1024
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/imhq_cmp.sv
module imhq_cmp (
  input  logic signed [imhq_pkg::KW-1:0] a,
  input  logic signed [imhq_pkg::KW-1:0] b,
  output logic                           lt
);
  import imhq_pkg::*;

  // signed order, smaller key is served first
  assign lt = (a < b);

endmodule

>>> rtl/indexed_min_heap_queue.sv
// Indexed min-heap queue: one request word in, exactly one response word out. The
// heap sits in position-indexed memories with a handle-indexed position table, and
// a small sequencer walks it through one shared key comparator, one level at a time.
// Insert and key decrease climb toward the root; pop descends from the root and key
// increase from the entry's own slot; remove climbs all the way to the root and then
// descends. The capacity is 1024 entries. After reset, and after each clear, a sweep
// over every handle empties the live-handle table; no request is taken meanwhile. A
// finished response waits in an output register and the next request may enter
// while it waits.
module indexed_min_heap_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  imhq_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output imhq_pkg::rsp_t  rsp
);
  import imhq_pkg::*;

  typedef enum logic [19:0] {
    S_CLR   = 20'h00001,
    S_IDLE  = 20'h00002,
    S_FETCH = 20'h00004,
    S_DISP  = 20'h00008,
    S_PAY   = 20'h00010,
    S_RMK   = 20'h00020,
    S_UPK   = 20'h00040,
    S_UPC1  = 20'h00080,
    S_UPC2  = 20'h00100,
    S_SUR   = 20'h00200,
    S_SUC   = 20'h00400,
    S_SUE   = 20'h00800,
    S_POP   = 20'h01000,
    S_LASTR = 20'h02000,
    S_LASTC = 20'h04000,
    S_SDL   = 20'h08000,
    S_SDR   = 20'h10000,
    S_SDC   = 20'h20000,
    S_SDE   = 20'h40000,
    S_FIN   = 20'h80000
  } state_t;

  state_t state;

  logic [2:0]           op;
  logic signed [KW-1:0] key_in;
  logic [31:0]          pay_in;
  logic [HW-1:0]        hin;
  logic [CW-1:0]        cnt, ftop, fresh;
  logic [HW-1:0]        sweep;
  logic                 clr_result;
  logic                 force_up;
  logic [HW-1:0]        cur, hr, h_m, bh;
  logic signed [KW-1:0] k_m, k_old, bk;
  logic                 take_l;
  logic [1:0]           status;
  logic [HW-1:0]        oh;
  logic signed [KW-1:0] ok_key;
  logic [31:0]          opay;

  // memory ports
  logic [HW-1:0]        pos_raddr, hpay_raddr;
  logic [HW-1:0]        p2h_rd, hpos_rd, fstk_rd;
  logic signed [KW-1:0] pkey_rd;
  logic [31:0]          hpay_rd;
  logic                 live_rd;
  logic                 mv_we;
  logic [HW-1:0]        mv_pos, mv_h;
  logic signed [KW-1:0] mv_k;
  logic                 hpay_we, live_we, live_wd, fstk_we;
  logic [HW-1:0]        hpay_waddr, live_waddr;

  logic signed [KW-1:0] cmp_a, cmp_b;
  logic                 lt;

  logic                 ins_ok;
  logic [HW-1:0]        ins_h;
  logic [HW-1:0]        parent;
  logic [CW-1:0]        lchild;
  logic [CW:0]          rchild;
  logic                 take_r;
  logic                 rsp_free;

  assign ins_ok = (cnt < CW'(CAPACITY)) && ((ftop != '0) || (fresh < CW'(CAPACITY)));
  assign ins_h = (ftop != '0) ? fstk_rd : fresh[HW-1:0];
  assign parent = (cur - HW'(1)) >> 1;
  assign lchild = {cur, 1'b1};
  assign rchild = {1'b0, lchild} + (CW+1)'(1);
  assign take_r = ((CW+1)'(cnt) > rchild) && lt;
  assign rsp_free = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE);

  imhq_cmp u_cmp (.a(cmp_a), .b(cmp_b), .lt(lt));

  always_comb begin
    cmp_a = pkey_rd;
    cmp_b = k_m;
    case (state)
      S_UPC1: begin
        cmp_a = k_m;
        cmp_b = k_old;
      end
      S_UPC2: begin
        cmp_a = k_old;
        cmp_b = k_m;
      end
      S_SDC: cmp_b = bk;
      default: ;
    endcase
  end

  always_comb begin
    pos_raddr = '0;
    case (state)
      S_DISP:  pos_raddr = hpos_rd;
      S_SUR:   pos_raddr = parent;
      S_LASTR: pos_raddr = cnt[HW-1:0];
      S_SDL:   pos_raddr = lchild[HW-1:0];
      S_SDR:   pos_raddr = rchild[HW-1:0];
      default: ;
    endcase
  end

  assign hpay_raddr = (op == OP_POP || op == OP_PEEK) ? p2h_rd : hin;

  // one move (or final placement) of an entry into a heap slot per cycle
  always_comb begin
    mv_we = 1'b0;
    mv_pos = cur;
    mv_h = h_m;
    mv_k = k_m;
    case (state)
      S_SUC: begin
        if (force_up || !lt) begin
          mv_we = 1'b1;
          mv_h = p2h_rd;
          mv_k = pkey_rd;
        end
      end
      S_SUE: mv_we = !force_up;
      S_SDC: begin
        if (take_r) begin
          mv_we = 1'b1;
          mv_h = p2h_rd;
          mv_k = pkey_rd;
        end else if (take_l) begin
          mv_we = 1'b1;
          mv_h = bh;
          mv_k = bk;
        end
      end
      S_SDE: mv_we = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    hpay_we = 1'b0;
    hpay_waddr = hin;
    live_we = 1'b0;
    live_waddr = hr;
    live_wd = 1'b0;
    fstk_we = 1'b0;
    case (state)
      S_DISP: begin
        if (op == OP_INSERT && ins_ok) begin
          hpay_we = 1'b1;
          hpay_waddr = ins_h;
          live_we = 1'b1;
          live_waddr = ins_h;
          live_wd = 1'b1;
        end else if (op == OP_UPDATE_PAY && live_rd) begin
          hpay_we = 1'b1;
        end
      end
      S_POP: begin
        live_we = 1'b1;
        fstk_we = (ftop < CW'(CAPACITY));
      end
      S_CLR: begin
        live_we = 1'b1;
        live_waddr = sweep;
      end
      default: ;
    endcase
  end

  imhq_ram #(.W(HW), .D(CAPACITY)) u_p2h (
    .clk(clk), .we(mv_we), .waddr(mv_pos), .wdata(mv_h),
    .raddr(pos_raddr), .rdata(p2h_rd));

  imhq_ram #(.W(KW), .D(CAPACITY)) u_pkey (
    .clk(clk), .we(mv_we), .waddr(mv_pos), .wdata(mv_k),
    .raddr(pos_raddr), .rdata(pkey_rd));

  imhq_ram #(.W(HW), .D(CAPACITY)) u_hpos (
    .clk(clk), .we(mv_we), .waddr(mv_h), .wdata(mv_pos),
    .raddr(hin), .rdata(hpos_rd));

  imhq_ram #(.W(32), .D(CAPACITY)) u_hpay (
    .clk(clk), .we(hpay_we), .waddr(hpay_waddr), .wdata(pay_in),
    .raddr(hpay_raddr), .rdata(hpay_rd));

  imhq_ram #(.W(1), .D(CAPACITY)) u_live (
    .clk(clk), .we(live_we), .waddr(live_waddr), .wdata(live_wd),
    .raddr(hin), .rdata(live_rd));

  imhq_ram #(.W(HW), .D(CAPACITY)) u_fstk (
    .clk(clk), .we(fstk_we), .waddr(ftop[HW-1:0]), .wdata(hr),
    .raddr(HW'(ftop - CW'(1))), .rdata(fstk_rd));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      cnt <= '0;
      ftop <= '0;
      fresh <= '0;
      sweep <= '0;
      clr_result <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // a word issued in S_FIN takes over from the one leaving
      if (rsp_valid && !rsp_stall && state != S_FIN) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          sweep <= sweep + HW'(1);
          if (sweep == HW'(CAPACITY - 1)) begin
            state <= clr_result ? S_FIN : S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            op <= req.opcode;
            key_in <= req.new_key;
            pay_in <= req.payload;
            hin <= req.handle;
            status <= ST_OK;
            oh <= '0;
            ok_key <= '0;
            opay <= '0;
            state <= S_FETCH;
          end
        end
        S_FETCH: state <= S_DISP;
        S_DISP: begin
          case (op)
            OP_INSERT: begin
              if (!ins_ok) begin
                status <= ST_FULL;
                state <= S_FIN;
              end else begin
                if (ftop != '0) begin
                  ftop <= ftop - CW'(1);
                end else begin
                  fresh <= fresh + CW'(1);
                end
                h_m <= ins_h;
                k_m <= key_in;
                oh <= ins_h;
                cur <= cnt[HW-1:0];
                cnt <= cnt + CW'(1);
                force_up <= 1'b0;
                state <= S_SUR;
              end
            end
            OP_POP, OP_PEEK: begin
              if (cnt == '0) begin
                status <= ST_EMPTY;
                state <= S_FIN;
              end else begin
                hr <= p2h_rd;
                oh <= p2h_rd;
                ok_key <= pkey_rd;
                state <= S_PAY;
              end
            end
            OP_REMOVE: begin
              if (!live_rd || cnt == '0) begin
                status <= ST_DEAD;
                state <= S_FIN;
              end else begin
                hr <= hin;
                oh <= hin;
                cur <= hpos_rd;
                state <= S_RMK;
              end
            end
            OP_UPDATE, OP_UPDATE_PAY: begin
              if (!live_rd) begin
                status <= ST_DEAD;
                state <= S_FIN;
              end else begin
                oh <= hin;
                cur <= hpos_rd;
                h_m <= hin;
                k_m <= key_in;
                state <= S_UPK;
              end
            end
            OP_CLEAR: begin
              cnt <= '0;
              ftop <= '0;
              fresh <= '0;
              sweep <= '0;
              clr_result <= 1'b1;
              state <= S_CLR;
            end
            default: state <= S_FIN;
          endcase
        end
        S_PAY: begin
          opay <= hpay_rd;
          state <= (op == OP_PEEK) ? S_FIN : S_POP;
        end
        S_RMK: begin
          ok_key <= pkey_rd;
          opay <= hpay_rd;
          force_up <= 1'b1;
          state <= S_SUR;
        end
        S_UPK: begin
          k_old <= pkey_rd;
          state <= S_UPC1;
        end
        S_UPC1: begin
          if (lt) begin
            force_up <= 1'b0;
            state <= S_SUR;
          end else begin
            state <= S_UPC2;
          end
        end
        S_UPC2: state <= lt ? S_SDL : S_FIN;
        S_SUR: state <= (cur == '0) ? S_SUE : S_SUC;
        S_SUC: begin
          // an equal parent still gives way; remove climbs regardless of keys
          if (!force_up && lt) begin
            state <= S_SUE;
          end else begin
            cur <= parent;
            state <= S_SUR;
          end
        end
        S_SUE: state <= force_up ? S_POP : S_FIN;
        S_POP: begin
          if (ftop < CW'(CAPACITY)) begin
            ftop <= ftop + CW'(1);
          end
          cnt <= cnt - CW'(1);
          state <= S_LASTR;
        end
        S_LASTR: state <= (cnt == '0) ? S_FIN : S_LASTC;
        S_LASTC: begin
          h_m <= p2h_rd;
          k_m <= pkey_rd;
          cur <= '0;
          state <= S_SDL;
        end
        S_SDL: state <= (lchild >= cnt) ? S_SDE : S_SDR;
        S_SDR: begin
          take_l <= lt;
          bk <= lt ? pkey_rd : k_m;
          bh <= p2h_rd;
          state <= S_SDC;
        end
        S_SDC: begin
          // right child only on a strict win, so the left one takes ties
          if (take_r) begin
            cur <= rchild[HW-1:0];
            state <= S_SDL;
          end else if (take_l) begin
            cur <= lchild[HW-1:0];
            state <= S_SDL;
          end else begin
            state <= S_SDE;
          end
        end
        S_SDE: state <= S_FIN;
        S_FIN: begin
          if (rsp_free) begin
            rsp_valid <= 1'b1;
            rsp.status <= status;
            rsp.out_handle <= oh;
            rsp.out_key <= ok_key;
            rsp.out_payload <= opay;
            rsp.entry_count <= cnt;
            state <= S_IDLE;
          end
        end
        default: state <= S_CLR;
      endcase
    end
  end

  // every allocated handle is either live in the heap or on the free stack
  a_handle_books: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (cnt + ftop == fresh))
    else $error("handle accounting broken");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    (cnt <= CW'(CAPACITY)) && (fresh <= CW'(CAPACITY)))
    else $error("entry count beyond capacity");

  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("sequencer state not one-hot");

  a_fin_issues: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) && rsp_free |=> rsp_valid && (state == S_IDLE))
    else $error("finished word not issued");

endmodule
